### sv/md4_pkg.sv
// md4 digest package: constants, round schedule helpers and shared types
package md4_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] K_ROUND2 = 32'o13240474631;
    localparam logic [31:0] K_ROUND3 = 32'o15666365641;

    localparam int unsigned ROUNDS     = 48;
    localparam int unsigned ROUND_BITS = 6;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned POS_BITS   = 4;

    localparam logic [31:0] PAD_ONE_WORD = 32'h00000080;

    localparam logic [ROUND_BITS-1:0] LAST_ROUND = ROUND_BITS'(ROUNDS - 1);
    localparam logic [POS_BITS-1:0]   LAST_POS   = POS_BITS'(BLOCK_WORDS - 1);
    localparam logic [POS_BITS-1:0]   LEN_POS    = POS_BITS'(BLOCK_WORDS - 2);

    typedef struct packed {
        logic                start;
        logic                init;
    } core_ctrl_t;

    typedef struct packed {
        logic                en;
        logic [POS_BITS-1:0] addr;
        logic [31:0]         data;
    } buf_wr_t;

    // message word used by round r
    function automatic logic [POS_BITS-1:0] order_idx(input logic [ROUND_BITS-1:0] r);
        logic [3:0] i;
        i = r[3:0];
        case (r[5:4])
            2'd0:    order_idx = i;
            2'd1:    order_idx = {i[1:0], i[3:2]};
            default: order_idx = {i[0], i[1], i[2], i[3]};
        endcase
    endfunction

    function automatic logic [4:0] shift_amt(input logic [ROUND_BITS-1:0] r);
        case ({r[5:4], r[1:0]})
            4'd0:    shift_amt = 5'd3;
            4'd1:    shift_amt = 5'd7;
            4'd2:    shift_amt = 5'd11;
            4'd3:    shift_amt = 5'd19;
            4'd4:    shift_amt = 5'd3;
            4'd5:    shift_amt = 5'd5;
            4'd6:    shift_amt = 5'd9;
            4'd7:    shift_amt = 5'd13;
            4'd8:    shift_amt = 5'd3;
            4'd9:    shift_amt = 5'd9;
            4'd10:   shift_amt = 5'd11;
            default: shift_amt = 5'd15;
        endcase
    endfunction

    // keep the valid bits of a partial last word and append the one bit
    function automatic logic [31:0] pad_word(input logic [31:0] w, input logic [4:0] v);
        logic [4:0]  sh;
        logic [31:0] keep_mask;
        logic [7:0]  bv;
        logic [7:0]  bmask;
        sh        = {v[4:3], 3'b000};
        keep_mask = (32'h1 << sh) - 32'h1;
        bv        = 8'((w >> sh) & 32'hff);
        bmask     = 8'h80 >> v[2:0];
        bv        = (bv | bmask) & ~(bmask - 8'h01);
        pad_word  = (w & keep_mask) | (32'(bv) << sh);
    endfunction

endpackage

### sv/md4_core.sv
// md4 compression engine: block buffer, chaining value and one shared round unit
module md4_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  md4_pkg::core_ctrl_t     ctrl,
    input  md4_pkg::buf_wr_t        wr,
    output logic                    done,
    output logic [3:0][31:0]        cv
);

    logic [31:0] buf_mem [md4_pkg::BLOCK_WORDS];

    logic [3:0][31:0]                cv_reg;
    logic [31:0]                     a_reg, b_reg, c_reg, d_reg;
    logic [md4_pkg::ROUND_BITS-1:0]  round_reg;
    logic                            busy_reg;
    logic                            add_reg;

    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] x_val;
    logic [31:0] sum;
    logic [63:0] dbl;
    logic [31:0] t_val;

    always_comb begin
        case (round_reg[5:4])
            2'd0: begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = 32'h0;
            end
            2'd1: begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = md4_pkg::K_ROUND2;
            end
            default: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = md4_pkg::K_ROUND3;
            end
        endcase
        x_val = buf_mem[md4_pkg::order_idx(round_reg)];
        sum   = a_reg + f_val + x_val + k_val;
        dbl   = {sum, sum} << md4_pkg::shift_amt(round_reg);
        t_val = dbl[63:32];
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            buf_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            add_reg   <= 1'b0;
            round_reg <= '0;
            cv_reg    <= {md4_pkg::IV_D, md4_pkg::IV_C, md4_pkg::IV_B, md4_pkg::IV_A};
        end else begin
            add_reg <= 1'b0;
            if (ctrl.init) begin
                cv_reg <= {md4_pkg::IV_D, md4_pkg::IV_C, md4_pkg::IV_B, md4_pkg::IV_A};
            end else if (ctrl.start) begin
                a_reg     <= cv_reg[0];
                b_reg     <= cv_reg[1];
                c_reg     <= cv_reg[2];
                d_reg     <= cv_reg[3];
                round_reg <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                a_reg     <= d_reg;
                d_reg     <= c_reg;
                c_reg     <= b_reg;
                b_reg     <= t_val;
                round_reg <= round_reg + 1'b1;
                if (round_reg == md4_pkg::LAST_ROUND) begin
                    busy_reg <= 1'b0;
                    add_reg  <= 1'b1;
                end
            end else if (add_reg) begin
                // feed-forward into the chaining value
                cv_reg[0] <= cv_reg[0] + a_reg;
                cv_reg[1] <= cv_reg[1] + b_reg;
                cv_reg[2] <= cv_reg[2] + c_reg;
                cv_reg[3] <= cv_reg[3] + d_reg;
            end
        end
    end

    assign done = add_reg;
    assign cv   = cv_reg;

endmodule

### sv/md4_message_digest.sv
// md4 message digest top level: word intake, padding sequencer and result register
// a non-last word goes into the block buffer; one that fills a block starts a compression
// (start, load, 48 rounds through the single round unit and feed-forward), during which no
// words are taken. a last word adds one padding word per cycle (paused during compressions)
// and, for a well-formed message, one or two compressions before the digest.
// aresetn (synchronous, active low) restores the initial chaining value and clears counts.
module md4_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_message_word,
    input  logic [5:0]  s_valid_bits,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_low,
    output logic [63:0] m_digest_high,
    output logic        m_status
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_COMP = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        PH_ONE   = 3'b001,
        PH_ZERO  = 3'b010,
        PH_LENHI = 3'b100
    } phase_t;

    state_t                         state_reg, state_next;
    phase_t                         phase_reg, phase_next;
    logic [md4_pkg::POS_BITS-1:0]   pos_reg, pos_next;
    logic [63:0]                    len_reg, len_next;
    logic                           mal_reg, mal_next;
    logic                           pad_reg, pad_next;
    logic                           final_reg, final_next;
    logic                           err_reg, err_next;
    logic                           start_reg, start_next;
    logic                           m_valid_reg, m_valid_next;
    logic [63:0]                    lo_reg, lo_next;
    logic [63:0]                    hi_reg, hi_next;
    logic                           status_reg, status_next;

    md4_pkg::core_ctrl_t            ctrl;
    md4_pkg::buf_wr_t               wr;
    logic                           core_done;
    logic [3:0][31:0]               cv;

    logic                           accept;
    logic                           full_word;
    logic                           out_free;

    md4_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .wr      (wr),
        .done    (core_done),
        .cv      (cv)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign full_word = s_valid_bits[5];
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        mal_next     = mal_reg;
        pad_next     = pad_reg;
        final_next   = final_reg;
        err_next     = err_reg;
        start_next   = 1'b0;
        m_valid_next = m_valid_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        status_next  = status_reg;
        wr           = '0;
        ctrl.start   = start_reg;
        ctrl.init    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_last_word) begin
                        if (!full_word) begin
                            mal_next = 1'b1;
                        end else if (!mal_reg) begin
                            len_next = len_reg + 64'd32;
                            wr.en    = 1'b1;
                            wr.addr  = pos_reg;
                            wr.data  = s_message_word;
                            pos_next = pos_reg + 1'b1;
                            if (pos_reg == md4_pkg::LAST_POS) begin
                                start_next = 1'b1;
                                state_next = ST_COMP;
                            end
                        end
                    end else if (mal_reg) begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        len_next = len_reg + (full_word ? 64'd32 : 64'(s_valid_bits[4:0]));
                        wr.en    = 1'b1;
                        wr.addr  = pos_reg;
                        wr.data  = full_word ? s_message_word
                                             : md4_pkg::pad_word(s_message_word,
                                                                 s_valid_bits[4:0]);
                        pos_next   = pos_reg + 1'b1;
                        pad_next   = 1'b1;
                        phase_next = full_word ? PH_ONE : PH_ZERO;
                        if (pos_reg == md4_pkg::LAST_POS) begin
                            start_next = 1'b1;
                            state_next = ST_COMP;
                        end else begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                wr.en    = 1'b1;
                wr.addr  = pos_reg;
                pos_next = pos_reg + 1'b1;
                case (phase_reg)
                    PH_ONE: begin
                        wr.data    = md4_pkg::PAD_ONE_WORD;
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO: begin
                        // zeros up to the length slot, then the low length word
                        if (pos_reg == md4_pkg::LEN_POS) begin
                            wr.data    = len_reg[31:0];
                            phase_next = PH_LENHI;
                        end else begin
                            wr.data = 32'h0;
                        end
                    end
                    default: begin
                        wr.data    = len_reg[63:32];
                        final_next = 1'b1;
                    end
                endcase
                if (pos_reg == md4_pkg::LAST_POS) begin
                    start_next = 1'b1;
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                if (core_done) begin
                    if (final_reg) begin
                        state_next = ST_DONE;
                    end else if (pad_reg) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    lo_next      = err_reg ? 64'h0 : {cv[1], cv[0]};
                    hi_next      = err_reg ? 64'h0 : {cv[3], cv[2]};
                    status_next  = err_reg;
                    ctrl.init    = 1'b1;
                    len_next     = '0;
                    pos_next     = '0;
                    mal_next     = 1'b0;
                    pad_next     = 1'b0;
                    final_next   = 1'b0;
                    err_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_ZERO;
            pos_reg     <= '0;
            len_reg     <= '0;
            mal_reg     <= 1'b0;
            pad_reg     <= 1'b0;
            final_reg   <= 1'b0;
            err_reg     <= 1'b0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            mal_reg     <= mal_next;
            pad_reg     <= pad_next;
            final_reg   <= final_next;
            err_reg     <= err_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        status_reg <= status_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_digest_low  = lo_reg;
    assign m_digest_high = hi_reg;
    assign m_status      = status_reg;

endmodule
